// File: src/rcks_pkg.sv
// ----------------------------------------------------------------------------
// RC4 key schedule package
// Shared constants, word types, controller commands and states.
// ----------------------------------------------------------------------------
package rcks_pkg;

  localparam int KEY_DEPTH  = 64;
  localparam int KEY_AW     = $clog2(KEY_DEPTH);
  localparam int CNT_W      = $clog2(KEY_DEPTH + 1);
  localparam int BYTE_W     = 8;
  localparam int PERM_DEPTH = 256;
  localparam int LEN_W      = 7;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd48;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] key_byte;
    logic [BYTE_W-1:0] read_index;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] entry_value;
    logic [BYTE_W-1:0] final_index;
    logic              schedule_done;
  } result_t;

  typedef struct packed {
    logic accept_load;
    logic accept_read;
    logic fill;
    logic rd_p;
    logic rd_j;
    logic wr_p;
    logic wr_j;
    logic read_out;
  } cmd_t;

  typedef struct packed {
    logic key_complete;
    logic p_last;
  } status_t;

  typedef enum logic [7:0] {
    ST_INIT = 8'b0000_0001,
    ST_IDLE = 8'b0000_0010,
    ST_READ = 8'b0000_0100,
    ST_FILL = 8'b0000_1000,
    ST_RDP  = 8'b0001_0000,
    ST_RDJ  = 8'b0010_0000,
    ST_WRP  = 8'b0100_0000,
    ST_WRJ  = 8'b1000_0000
  } state_t;

endpackage

// File: src/rcks_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rcks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/rcks_ctrl.sv
// ----------------------------------------------------------------------------
// RC4 key schedule controller
// Sequences reset fill, reads, key loads and the 256-step swap schedule.
// ----------------------------------------------------------------------------
module rcks_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             kind,
  input  rcks_pkg::status_t status,
  output rcks_pkg::cmd_t   cmd,
  output logic             busy
);

  rcks_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcks_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      rcks_pkg::ST_INIT: begin
        cmd.fill = 1'b1;
        if (status.p_last) state_next = rcks_pkg::ST_IDLE;
      end
      rcks_pkg::ST_IDLE: begin
        if (start) begin
          if (kind == rcks_pkg::KIND_READ) begin
            cmd.accept_read = 1'b1;
            state_next      = rcks_pkg::ST_READ;
          end else begin
            cmd.accept_load = 1'b1;
            if (status.key_complete) state_next = rcks_pkg::ST_FILL;
          end
        end
      end
      rcks_pkg::ST_READ: begin
        cmd.read_out = 1'b1;
        state_next   = rcks_pkg::ST_IDLE;
      end
      rcks_pkg::ST_FILL: begin
        cmd.fill = 1'b1;
        if (status.p_last) state_next = rcks_pkg::ST_RDP;
      end
      rcks_pkg::ST_RDP: begin
        cmd.rd_p   = 1'b1;
        state_next = rcks_pkg::ST_RDJ;
      end
      rcks_pkg::ST_RDJ: begin
        cmd.rd_j   = 1'b1;
        state_next = rcks_pkg::ST_WRP;
      end
      rcks_pkg::ST_WRP: begin
        cmd.wr_p   = 1'b1;
        state_next = rcks_pkg::ST_WRJ;
      end
      rcks_pkg::ST_WRJ: begin
        cmd.wr_j   = 1'b1;
        state_next = status.p_last ? rcks_pkg::ST_IDLE : rcks_pkg::ST_RDP;
      end
      default: begin
        state_next = rcks_pkg::ST_INIT;
      end
    endcase
  end

  assign busy = (state != rcks_pkg::ST_IDLE);

endmodule

// File: src/rcks_dp.sv
// ----------------------------------------------------------------------------
// RC4 key schedule datapath
// Key store, permutation memory, indices, length register and result word.
// ----------------------------------------------------------------------------
module rcks_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  rcks_pkg::cmd_t               cmd,
  input  rcks_pkg::item_t              item,
  input  logic                         cfg_we,
  input  logic [rcks_pkg::LEN_W-1:0]   cfg_data,
  output rcks_pkg::status_t            status,
  output rcks_pkg::result_t            result,
  output logic                         result_strobe
);

  localparam int BW = rcks_pkg::BYTE_W;
  localparam int LW = rcks_pkg::LEN_W;
  localparam int CW = rcks_pkg::CNT_W;
  localparam int KW = rcks_pkg::KEY_AW;

  logic [LW-1:0] key_length;
  logic [CW-1:0] loaded_count;
  logic          done_flag;
  logic [BW-1:0] swap_index;
  logic [BW-1:0] p;
  logic [KW-1:0] kp;
  logic [BW-1:0] j;
  logic [BW-1:0] t;

  logic [LW-1:0] eff_len;
  logic [CW-1:0] count_inc;
  logic [LW-1:0] kp_inc;
  logic          kp_wrap;
  logic [BW-1:0] jn;
  logic          p_last;
  logic          key_we;

  logic          perm_we;
  logic [BW-1:0] perm_waddr;
  logic [BW-1:0] perm_wdata;
  logic [BW-1:0] perm_raddr;
  logic [BW-1:0] perm_rdata;
  logic [BW-1:0] key_rdata;

  always_comb begin
    eff_len = key_length;
    if (key_length == '0) eff_len = LW'(1);
    if (key_length > LW'(rcks_pkg::KEY_DEPTH)) eff_len = LW'(rcks_pkg::KEY_DEPTH);
  end

  assign count_inc           = loaded_count + CW'(1);
  assign status.key_complete = (count_inc >= CW'(eff_len));
  assign p_last              = &p;
  assign status.p_last       = p_last;
  assign kp_inc              = LW'(kp) + LW'(1);
  assign kp_wrap             = (kp_inc >= eff_len);
  assign jn                  = j + perm_rdata + key_rdata;
  assign key_we              = cmd.accept_load && (loaded_count < CW'(rcks_pkg::KEY_DEPTH));

  assign perm_we    = cmd.fill | cmd.wr_p | cmd.wr_j;
  assign perm_waddr = cmd.wr_j ? j : p;
  assign perm_wdata = cmd.fill ? p : (cmd.wr_p ? perm_rdata : t);
  assign perm_raddr = cmd.accept_read ? item.read_index : (cmd.rd_j ? jn : p);

  rcks_ram #(
    .WIDTH(BW),
    .DEPTH(rcks_pkg::PERM_DEPTH)
  ) u_perm (
    .clk  (clk),
    .we   (perm_we),
    .waddr(perm_waddr),
    .wdata(perm_wdata),
    .raddr(perm_raddr),
    .rdata(perm_rdata)
  );

  rcks_ram #(
    .WIDTH(BW),
    .DEPTH(rcks_pkg::KEY_DEPTH)
  ) u_key (
    .clk  (clk),
    .we   (key_we),
    .waddr(loaded_count[KW-1:0]),
    .wdata(item.key_byte),
    .raddr(kp),
    .rdata(key_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length    <= rcks_pkg::LEN_RESET;
      loaded_count  <= '0;
      done_flag     <= 1'b0;
      swap_index    <= '0;
      p             <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (cfg_we) key_length <= cfg_data;
      if (cmd.fill) p <= p + BW'(1);
      if (cmd.accept_load) begin
        if (status.key_complete) begin
          loaded_count <= '0;
        end else begin
          loaded_count  <= count_inc;
          result_strobe <= 1'b1;
          if (loaded_count == '0) done_flag <= 1'b0;
        end
      end
      if (cmd.read_out) result_strobe <= 1'b1;
      if (cmd.wr_j) begin
        p <= p + BW'(1);
        if (p_last) begin
          swap_index    <= j;
          done_flag     <= 1'b1;
          result_strobe <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept_load) begin
      j  <= '0;
      kp <= '0;
      result.entry_value   <= '0;
      result.final_index   <= swap_index;
      result.schedule_done <= (loaded_count == '0) ? 1'b0 : done_flag;
    end
    if (cmd.read_out) begin
      result.entry_value   <= perm_rdata;
      result.final_index   <= swap_index;
      result.schedule_done <= done_flag;
    end
    if (cmd.rd_j) begin
      t <= perm_rdata;
      j <= jn;
    end
    if (cmd.wr_j) begin
      kp <= kp_wrap ? '0 : kp_inc[KW-1:0];
      if (p_last) begin
        result.entry_value   <= '0;
        result.final_index   <= j;
        result.schedule_done <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_load_word_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept_load && !status.key_complete) |=> (result_strobe && result.entry_value == '0))
    else $error("key load word carries nonzero entry");

  a_sched_end_word: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_j && p_last) |=> (result_strobe && result.schedule_done && result.final_index == swap_index))
    else $error("schedule end word missing or wrong");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_count < CW'(rcks_pkg::KEY_DEPTH))
    else $error("loaded count out of range");
`endif

endmodule

// File: src/rc4_key_schedule_unit.sv
// ----------------------------------------------------------------------------
// RC4 key schedule unit
// Loads key bytes, runs the RC4 key schedule, serves permutation reads.
// ----------------------------------------------------------------------------
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-------------------------------
//  input    | start, busy, item              | taken when start & !busy
//  result   | result_strobe, result          | one-cycle strobe, no stall
//  config   | cfg_we, cfg_data               | written when cfg_we
//
//  Key load that does not finish a key: word next cycle, busy stays low.
//  Read: registered permutation memory read, busy high, then the word.
//  Key load that finishes a key: the permutation is filled with the
//  identity, then per swap step (one read and one write port, registered
//  read) S[p] and S[j] are read and both written back; then the word.
//  After reset busy is high while the permutation is set to the identity;
//  no word is given for that pass.
// ----------------------------------------------------------------------------
module rc4_key_schedule_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  rcks_pkg::item_t              item,
  output logic                         result_strobe,
  output rcks_pkg::result_t            result,
  input  logic                         cfg_we,
  input  logic [rcks_pkg::LEN_W-1:0]   cfg_data
);

  rcks_pkg::cmd_t    cmd;
  rcks_pkg::status_t status;

  rcks_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (item.kind),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  rcks_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .status       (status),
    .result       (result),
    .result_strobe(result_strobe)
  );

endmodule

// File: tb/rc4_key_schedule_unit_test.sv
// ----------------------------------------------------------------------------
// RC4 key schedule unit test
// Drives key loads and permutation reads through the command port, rewrites
// the key length between phases, and checks every result word against a
// shadow permutation kept by the testbench.
// ----------------------------------------------------------------------------
class ksa_shadow;
  logic [rcks_pkg::BYTE_W-1:0] perm [rcks_pkg::PERM_DEPTH];
  logic [rcks_pkg::BYTE_W-1:0] key_bytes [rcks_pkg::KEY_DEPTH];
  int unsigned                 loaded;
  logic [rcks_pkg::BYTE_W-1:0] swap_j;
  logic                        done;
  logic [rcks_pkg::LEN_W-1:0]  key_len;
  rcks_pkg::result_t           pending_words [$];
  int unsigned                 fails;

  function new();
    for (int i = 0; i < rcks_pkg::PERM_DEPTH; i++) perm[i] = i[rcks_pkg::BYTE_W-1:0];
    for (int i = 0; i < rcks_pkg::KEY_DEPTH; i++) key_bytes[i] = '0;
    loaded  = 0;
    swap_j  = '0;
    done    = 1'b0;
    key_len = rcks_pkg::LEN_RESET;
    fails   = 0;
  endfunction

  function void set_len(logic [rcks_pkg::LEN_W-1:0] v);
    key_len = v;
  endfunction

  function int unsigned eff_len();
    if (key_len == 0) return 1;
    if (key_len > rcks_pkg::KEY_DEPTH) return rcks_pkg::KEY_DEPTH;
    return 32'(key_len);
  endfunction

  function void rekey(int unsigned n);
    logic [rcks_pkg::BYTE_W-1:0] t;
    logic [rcks_pkg::BYTE_W-1:0] j;
    int unsigned                 kp;
    j  = '0;
    kp = 0;
    for (int p = 0; p < rcks_pkg::PERM_DEPTH; p++) perm[p] = p[rcks_pkg::BYTE_W-1:0];
    for (int p = 0; p < rcks_pkg::PERM_DEPTH; p++) begin
      t       = perm[p];
      j       = j + t + key_bytes[kp];
      perm[p] = perm[j];
      perm[j] = t;
      kp++;
      if (kp >= n) kp = 0;
    end
    swap_j = j;
  endfunction

  function void take_item(rcks_pkg::item_t w);
    rcks_pkg::result_t r;
    int unsigned       n;
    r.entry_value = '0;
    if (w.kind == rcks_pkg::KIND_LOAD) begin
      n = eff_len();
      if (loaded == 0) done = 1'b0;
      if (loaded < rcks_pkg::KEY_DEPTH) key_bytes[loaded] = w.key_byte;
      loaded++;
      if (loaded >= n) begin
        rekey(n);
        loaded = 0;
        done   = 1'b1;
      end
    end else begin
      r.entry_value = perm[w.read_index];
    end
    r.final_index   = swap_j;
    r.schedule_done = done;
    pending_words.push_back(r);
  endfunction

  function void compare_word(rcks_pkg::result_t got);
    rcks_pkg::result_t want;
    if (pending_words.size() == 0) begin
      $error("result word with nothing pending: %h", got);
      fails++;
      return;
    end
    want = pending_words.pop_front();
    if (got.entry_value !== want.entry_value) begin
      $error("entry_value: expected %0d, actual %0d", want.entry_value, got.entry_value);
      fails++;
    end
    if (got.final_index !== want.final_index) begin
      $error("final_index: expected %0d, actual %0d", want.final_index, got.final_index);
      fails++;
    end
    if (got.schedule_done !== want.schedule_done) begin
      $error("schedule_done: expected %0d, actual %0d",
             want.schedule_done, got.schedule_done);
      fails++;
    end
  endfunction

  function int pending();
    return pending_words.size();
  endfunction
endclass

module rc4_key_schedule_unit_test;

  localparam int unsigned ITEMS       = 450;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int          BW          = rcks_pkg::BYTE_W;
  localparam int          LW          = rcks_pkg::LEN_W;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  rcks_pkg::item_t   item;
  logic              result_strobe;
  rcks_pkg::result_t result;
  logic              cfg_we;
  logic [LW-1:0]     cfg_data;

  ksa_shadow   shadow = new();
  int unsigned idle_pct;
  int unsigned sent;
  int unsigned cycle_count;

  rc4_key_schedule_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_strobe(result_strobe),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst === 1'b0) begin
      if (cfg_we === 1'b1) shadow.set_len(cfg_data);
      if (start === 1'b1 && busy === 1'b0) shadow.take_item(item);
      if (result_strobe === 1'b1) shadow.compare_word(result);
    end
  end

  initial begin
    cycle_count = 0;
    wait (cycle_count >= CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_word(input logic kind, input logic [BW-1:0] kb,
                           input logic [BW-1:0] ri);
    rcks_pkg::item_t w;
    w.kind       = kind;
    w.key_byte   = kb;
    w.read_index = ri;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= w;
    do @(posedge clk); while (busy !== 1'b0);
    sent++;
  endtask

  task automatic load_key_byte(input logic [BW-1:0] kb);
    send_word(rcks_pkg::KIND_LOAD, kb, BW'($urandom_range(0, 255)));
  endtask

  task automatic read_perm(input logic [BW-1:0] ri);
    send_word(rcks_pkg::KIND_READ, BW'($urandom_range(0, 255)), ri);
  endtask

  // hold off until every word is back, then write the length
  task automatic set_length(input logic [LW-1:0] v);
    start <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    logic [LW-1:0] len;
    int unsigned   eff;
    int unsigned   nload;

    start    <= 1'b0;
    item     <= '0;
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    rst      <= 1'b1;
    sent     = 0;
    idle_pct = 18;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    read_perm(8'h00);
    read_perm(8'hFF);

    set_length(7'd1);
    load_key_byte(8'h00);
    read_perm(8'hFF);
    load_key_byte(8'hFF);
    read_perm(8'h00);
    read_perm(8'h80);

    set_length(7'd0);
    load_key_byte(8'h5A);
    read_perm(8'hA5);

    set_length(7'd3);
    load_key_byte(8'h01);
    load_key_byte(8'h02);
    load_key_byte(8'h03);
    read_perm(8'h7F);

    set_length(7'd10);
    load_key_byte(8'hC3);
    load_key_byte(8'h3C);
    load_key_byte(8'hF0);
    load_key_byte(8'h0F);
    read_perm(8'h01);
    read_perm(8'hFE);
    read_perm(8'h55);

    // shrink the length mid-key: next load completes it
    set_length(7'd2);
    load_key_byte(8'hAA);
    read_perm(8'h10);

    set_length(7'd127);
    load_key_byte(8'h99);
    load_key_byte(8'h66);
    read_perm(8'h20);

    while (sent < ITEMS) begin
      idle_pct = (sent < ITEMS / 3) ? 18 : (sent < 2 * ITEMS / 3) ? 76 : 0;
      case ($urandom_range(0, 11))
        0:       len = 7'd64;
        1:       len = 7'd127;
        2:       len = 7'd0;
        3:       len = 7'd1;
        4:       len = LW'($urandom_range(65, 126));
        default: len = LW'($urandom_range(2, 12));
      endcase
      set_length(len);
      eff = (len == 0) ? 1 : (len > rcks_pkg::KEY_DEPTH) ? rcks_pkg::KEY_DEPTH : 32'(len);
      repeat ($urandom_range(1, 3)) begin
        nload = ($urandom_range(0, 4) == 0) ? $urandom_range(1, eff) : eff;
        repeat (nload) begin
          if (sent < ITEMS) begin
            if ($urandom_range(0, 9) == 0) read_perm(BW'($urandom_range(0, 255)));
            load_key_byte(BW'($urandom_range(0, 255)));
          end
        end
        repeat ($urandom_range(1, 6)) begin
          if (sent < ITEMS) read_perm(BW'($urandom_range(0, 255)));
        end
      end
    end

    start <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (shadow.fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
